// ----- rtl/core/lpwd_pkg.sv -----
`default_nettype none
package lpwd_pkg;

    localparam int MAX_WORDS = 1024;
    localparam int IDX_W     = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
    localparam int TDATA_W   = 64;

    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_OVER  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_id;
        logic [15:0] msg_len;
        logic [9:0]  word_index;
        logic [15:0] payload_word;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/lpwd_skid.sv -----
`default_nettype none
module lpwd_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lpwd_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lpwd_pkg::result_t     out_data
);
    import lpwd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // hold the word aside while the output stalls
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (!skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/length_prefixed_word_deframer_top.sv -----
`default_nettype none
// A result is registered in the skid buffer before it leaves on m_tdata.
// Throughput: one byte per cycle while m_tready is high; the output register plus one skid
// entry keep s_tready high while a single result waits, and s_tready drops for every byte
// while a second result is held in the skid entry.
// After an overflow result every accepted byte is dropped until reset.
// Reset: aresetn is synchronous, active low, and clears all framing state and both valid flags.
module length_prefixed_word_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte [7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // msg_id [15:0], msg_len [31:16], word_index [41:32], payload_word [57:42], zero [63:58]
    output logic [lpwd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]       m_tuser,   // kind [1:0]
    output logic             m_tlast
);
    import lpwd_pkg::*;

    localparam logic [1:0] PH_ID      = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    logic             byte_phase_reg, byte_phase_next;
    logic [7:0]       low_byte_reg, low_byte_next;
    logic [1:0]       frame_phase_reg, frame_phase_next;
    logic [15:0]      cur_id_reg, cur_id_next;
    logic [15:0]      cur_len_reg, cur_len_next;
    logic [15:0]      words_left_reg, words_left_next;
    logic [IDX_W-1:0] next_index_reg, next_index_next;

    logic        in_fire;
    logic        skid_ready;
    logic        res_valid;
    result_t     res;
    result_t     out_res;
    logic [15:0] word;
    logic [15:0] left_dec;

    assign s_tready = skid_ready;
    assign in_fire  = s_tvalid && skid_ready;
    assign word     = {s_tdata, low_byte_reg};
    assign left_dec = words_left_reg - 16'd1;

    always_comb begin
        byte_phase_next  = byte_phase_reg;
        low_byte_next    = low_byte_reg;
        frame_phase_next = frame_phase_reg;
        cur_id_next      = cur_id_reg;
        cur_len_next     = cur_len_reg;
        words_left_next  = words_left_reg;
        next_index_next  = next_index_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_WORD;
        res.msg_id       = cur_id_reg;
        res.msg_len      = cur_len_reg;
        res.word_index   = 10'(next_index_reg);
        res.payload_word = word;
        res.last         = 1'b0;
        if (in_fire && frame_phase_reg != PH_HALT) begin
            if (!byte_phase_reg) begin
                low_byte_next   = s_tdata;
                byte_phase_next = 1'b1;
            end else begin
                byte_phase_next = 1'b0;
                case (frame_phase_reg)
                    PH_ID: begin
                        cur_id_next      = word;
                        next_index_next  = '0;
                        frame_phase_next = PH_LEN;
                    end
                    PH_LEN: begin
                        cur_len_next    = word;
                        words_left_next = word;
                        next_index_next = '0;
                        res.msg_len     = word;
                        if (word == 16'd0) begin
                            frame_phase_next = PH_ID;
                            res_valid        = 1'b1;
                            res.kind         = KIND_EMPTY;
                            res.word_index   = '0;
                            res.payload_word = '0;
                            res.last         = 1'b1;
                        end else begin
                            frame_phase_next = PH_PAYLOAD;
                        end
                    end
                    default: begin
                        words_left_next = left_dec;
                        next_index_next = IDX_W'(next_index_reg + 1'b1);
                        res_valid       = 1'b1;
                        if (next_index_reg == IDX_W'(MAX_WORDS - 1)) begin
                            frame_phase_next = PH_HALT;
                            res.kind         = KIND_OVER;
                            res.last         = 1'b1;
                        end else if (left_dec == 16'd0) begin
                            frame_phase_next = PH_ID;
                            res.last         = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_phase_reg  <= 1'b0;
            low_byte_reg    <= '0;
            frame_phase_reg <= PH_ID;
            cur_id_reg      <= '0;
            cur_len_reg     <= '0;
            words_left_reg  <= '0;
            next_index_reg  <= '0;
        end else begin
            byte_phase_reg  <= byte_phase_next;
            low_byte_reg    <= low_byte_next;
            frame_phase_reg <= frame_phase_next;
            cur_id_reg      <= cur_id_next;
            cur_len_reg     <= cur_len_next;
            words_left_reg  <= words_left_next;
            next_index_reg  <= next_index_next;
        end
    end

    lpwd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (skid_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {6'b0, out_res.payload_word, out_res.word_index,
                      out_res.msg_len, out_res.msg_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import lpwd_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_ID,
        AWAIT_LEN,
        IN_PAYLOAD,
        HALTED
    } frame_state_e;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int bytes_sent     = 0;

    // deframer state as seen from the byte stream
    frame_state_e frame;
    logic         hi_phase;
    logic [7:0]   low_hold;
    logic [15:0]  cur_id;
    logic [15:0]  cur_len;
    logic [15:0]  words_left;
    int           next_idx;

    result_t pending_results[$];

    length_prefixed_word_deframer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", m_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[15:0] !== want.msg_id)
                    report_mismatch("msg_id", m_tdata[15:0], want.msg_id);
                if (m_tdata[31:16] !== want.msg_len)
                    report_mismatch("msg_len", m_tdata[31:16], want.msg_len);
                if (m_tdata[41:32] !== want.word_index)
                    report_mismatch("word_index", m_tdata[41:32], want.word_index);
                if (m_tdata[57:42] !== want.payload_word)
                    report_mismatch("payload_word", m_tdata[57:42], want.payload_word);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    function automatic void clear_frame_state();
        frame      = AWAIT_ID;
        hi_phase   = 1'b0;
        low_hold   = 8'h00;
        cur_id     = 16'h0000;
        cur_len    = 16'h0000;
        words_left = 16'h0000;
        next_idx   = 0;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input int idx,
                                        input logic [15:0] word, input logic last);
        result_t r;
        r.kind         = kind;
        r.msg_id       = cur_id;
        r.msg_len      = cur_len;
        r.word_index   = idx[9:0];
        r.payload_word = word;
        r.last         = last;
        pending_results.push_back(r);
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        logic [15:0] w;
        int          idx;
        if (frame == HALTED)
            return;
        if (!hi_phase) begin
            low_hold = b;
            hi_phase = 1'b1;
            return;
        end
        hi_phase = 1'b0;
        w = {b, low_hold};
        case (frame)
            AWAIT_ID: begin
                cur_id   = w;
                next_idx = 0;
                frame    = AWAIT_LEN;
            end
            AWAIT_LEN: begin
                cur_len    = w;
                words_left = w;
                next_idx   = 0;
                if (w == 16'h0000) begin
                    frame = AWAIT_ID;
                    push_result(KIND_EMPTY, 0, 16'h0000, 1'b1);
                end else begin
                    frame = IN_PAYLOAD;
                end
            end
            default: begin
                idx        = next_idx;
                words_left = words_left - 16'd1;
                next_idx   = next_idx + 1;
                if (next_idx >= MAX_WORDS) begin
                    frame = HALTED;
                    push_result(KIND_OVER, idx, w, 1'b1);
                end else if (words_left == 16'h0000) begin
                    frame = AWAIT_ID;
                    push_result(KIND_WORD, idx, w, 1'b1);
                end else begin
                    push_result(KIND_WORD, idx, w, 1'b0);
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    task automatic send_message(input logic [15:0] id, input logic [15:0] len);
        send_word(id);
        send_word(len);
        for (int i = 0; i < len; i++)
            send_word(16'($urandom));
    endtask

    task automatic test_directed();
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h0000);
        send_word(16'h0001);
        send_word(16'hFFFF);
        send_word(16'h5AA5);
        send_word(16'h0002);
        send_word(16'h0000);
        send_word(16'h8001);
        send_word(16'h00FF);
        send_word(16'h0001);
        send_word(16'hFF00);
    endtask

    task automatic test_random_messages(input int n_bytes);
        int          stop_at;
        int          pick;
        logic [15:0] len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = 16'd0;
            else if (pick < 85)
                len = 16'($urandom_range(6, 1));
            else
                len = 16'($urandom_range(40, 7));
            send_message(16'($urandom), len);
        end
    endtask

    // message one word too long for the buffer, then bytes that must be dropped
    task automatic test_overflow();
        send_message(16'hC3C3, 16'(MAX_WORDS));
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        clear_frame_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        src_gap_pct    = 32;
        sink_stall_pct = 51;
        test_directed();
        test_random_messages(380);

        src_gap_pct    = 51;
        sink_stall_pct = 32;
        test_random_messages(380);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_messages(380);
        test_overflow();

        wait_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/lpwd_pkg.sv
rtl/core/lpwd_skid.sv
rtl/core/length_prefixed_word_deframer_top.sv
bench/testbench.sv
